[hw/rtl/assert_macros.svh]
// Assertion macros for the register machine executor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication under active-low reset.
`define RME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rme assertion failed");
// Next-cycle implication under active-low reset.
`define RME_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rme assertion failed");
`else
`define RME_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RME_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/rme_pkg.sv]
// Types and constants of the register machine executor.
`timescale 1ns / 1ps
package rme_pkg;

  typedef enum logic [3:0] {
    OP_ADDR = 4'd0,
    OP_ADDI = 4'd1,
    OP_MULR = 4'd2,
    OP_MULI = 4'd3,
    OP_BANR = 4'd4,
    OP_BANI = 4'd5,
    OP_BORR = 4'd6,
    OP_BORI = 4'd7,
    OP_SETR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTIR = 4'd10,
    OP_GTRR = 4'd11,
    OP_GTRI = 4'd12,
    OP_EQIR = 4'd13,
    OP_EQRI = 4'd14,
    OP_EQRR = 4'd15
  } opcode_e;

  typedef enum logic {
    REQ_EXEC    = 1'b0,
    REQ_RESTART = 1'b1
  } req_e;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_POINTER_REGISTER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PROGRAM_LENGTH   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_VALUE      = 2'd2;

  typedef struct packed {
    req_e               req_type;
    opcode_e            opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [2:0]         dest_index;
  } in_t;

  typedef struct packed {
    logic signed [31:0] next_pointer;
    logic               running;
    logic signed [31:0] first_register;
    logic               bad_index;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] reg_index;
    logic [31:0]        wdata;
  } cfg_t;

endpackage

[hw/rtl/rme_chan_if.sv]
// Valid/ready channel interface carrying one payload per transaction.
`timescale 1ns / 1ps
interface rme_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/register_machine_executor_unit.sv]
// Register machine executor: one instruction or restart per transaction.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Executes one instruction per cycle, back to back: a transaction is taken into an input
// register, and the execute stage reads the register file, computes the result (one
// multiplier, compare and increment), writes the destination and the pointer register
// and loads the result register; a restart clears the registers and loads register 0
// with the start value. Registers update with the result register, so a dependent
// instruction can follow in the very next cycle. Throughput is one transaction per cycle
// while the output side takes results. Configuration writes are accepted every cycle and
// must only happen while the block is idle. No clearing pass is needed after reset.
module register_machine_executor_unit #(
  parameter int NUM_REGISTERS = 6,
  parameter int DATA_WIDTH    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rme_chan_if.sink    in_i,
  rme_chan_if.source  out_o,
  rme_chan_if.sink    cfg_i
);

  localparam int IdxW = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
  localparam int CmpW = (DATA_WIDTH > 16) ? DATA_WIDTH : 16;

  // configuration
  logic [2:0]         pointer_register_q;
  logic [15:0]        program_length_q;
  logic signed [31:0] start_value_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pointer_register_q <= '0;
      program_length_q   <= '0;
      start_value_q      <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.reg_index)
        rme_pkg::CFG_POINTER_REGISTER: pointer_register_q <= cfg_i.data.wdata[2:0];
        rme_pkg::CFG_PROGRAM_LENGTH:   program_length_q   <= cfg_i.data.wdata[15:0];
        rme_pkg::CFG_START_VALUE:      start_value_q      <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic          s1_valid_q;
  rme_pkg::in_t  s1_q;
  logic          out_valid_q;
  rme_pkg::out_t out_q;
  rme_pkg::out_t out_d;
  logic          exe_go;

  assign exe_go      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || exe_go;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (exe_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= in_i.data;
    end
    if (exe_go) begin
      out_q <= out_d;
    end
  end

  // execute stage
  logic [DATA_WIDTH-1:0] regs_q [NUM_REGISTERS];
  logic [DATA_WIDTH-1:0] regs_d [NUM_REGISTERS];
  logic                  a_ok, b_ok, dest_ok, ptr_ok;
  logic                  a_reg, b_reg, bad;
  logic [IdxW-1:0]       dest_idx, ptr_idx;
  logic [DATA_WIDTH-1:0] va, vb, ia, ib, src_b, prod, result;
  logic [DATA_WIDTH-1:0] restart_value, new_ptr;
  logic                  is_restart;

  assign is_restart = (s1_q.req_type == rme_pkg::REQ_RESTART);
  assign a_ok    = $unsigned(s1_q.operand_a) < 32'(NUM_REGISTERS);
  assign b_ok    = $unsigned(s1_q.operand_b) < 32'(NUM_REGISTERS);
  assign dest_ok = 32'(s1_q.dest_index) < 32'(NUM_REGISTERS);
  assign ptr_ok  = 32'(pointer_register_q) < 32'(NUM_REGISTERS);
  assign dest_idx = IdxW'(s1_q.dest_index);
  assign ptr_idx  = IdxW'(pointer_register_q);

  assign va = a_ok ? regs_q[s1_q.operand_a[IdxW-1:0]] : '0;
  assign vb = b_ok ? regs_q[s1_q.operand_b[IdxW-1:0]] : '0;
  assign ia = DATA_WIDTH'(s1_q.operand_a);
  assign ib = DATA_WIDTH'(s1_q.operand_b);
  assign restart_value = DATA_WIDTH'(start_value_q);

  always_comb begin
    a_reg = 1'b1;
    b_reg = 1'b0;
    src_b = ib;
    case (s1_q.opcode)
      rme_pkg::OP_ADDR, rme_pkg::OP_MULR, rme_pkg::OP_BANR, rme_pkg::OP_BORR,
      rme_pkg::OP_GTRR, rme_pkg::OP_EQRR: begin
        b_reg = 1'b1;
        src_b = vb;
      end
      rme_pkg::OP_SETI: begin
        a_reg = 1'b0;
      end
      rme_pkg::OP_GTIR, rme_pkg::OP_EQIR: begin
        a_reg = 1'b0;
        b_reg = 1'b1;
        src_b = vb;
      end
      default: ;
    endcase
  end

  assign prod = DATA_WIDTH'(va * src_b);

  always_comb begin
    case (s1_q.opcode)
      rme_pkg::OP_ADDR, rme_pkg::OP_ADDI: result = va + src_b;
      rme_pkg::OP_MULR, rme_pkg::OP_MULI: result = prod;
      rme_pkg::OP_BANR, rme_pkg::OP_BANI: result = va & src_b;
      rme_pkg::OP_BORR, rme_pkg::OP_BORI: result = va | src_b;
      rme_pkg::OP_SETR: result = va;
      rme_pkg::OP_SETI: result = ia;
      rme_pkg::OP_GTIR: result = DATA_WIDTH'($signed(ia) > $signed(src_b));
      rme_pkg::OP_GTRR, rme_pkg::OP_GTRI:
        result = DATA_WIDTH'($signed(va) > $signed(src_b));
      rme_pkg::OP_EQIR: result = DATA_WIDTH'(ia == src_b);
      default: result = DATA_WIDTH'(va == src_b);
    endcase
  end

  assign bad = !dest_ok || (a_reg && !a_ok) || (b_reg && !b_ok);

  always_comb begin
    regs_d = regs_q;
    if (is_restart) begin
      for (int i = 0; i < NUM_REGISTERS; i++) begin
        regs_d[i] = '0;
      end
      regs_d[0] = restart_value;
    end else begin
      if (!bad) begin
        regs_d[dest_idx] = result;
      end
      if (ptr_ok) begin
        regs_d[ptr_idx] = regs_d[ptr_idx] + DATA_WIDTH'(1);
      end
    end
  end

  assign new_ptr = ptr_ok ? regs_d[ptr_idx] : '0;

  always_comb begin
    out_d.next_pointer   = 32'(new_ptr);
    out_d.running        = ptr_ok && !new_ptr[DATA_WIDTH-1] &&
                           (CmpW'(new_ptr) < CmpW'(program_length_q));
    out_d.first_register = 32'(regs_d[0]);
    out_d.bad_index      = !is_restart && bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGISTERS; i++) begin
        regs_q[i] <= '0;
      end
    end else if (exe_go) begin
      regs_q <= regs_d;
    end
  end

  // assertions
  `RME_ASSERT_NXT(a_restart_loads_r0, clk_i, rst_ni,
    exe_go && is_restart, out_q.first_register == $past(32'(restart_value)))
  `RME_ASSERT_NXT(a_unbound_pointer, clk_i, rst_ni,
    exe_go && !ptr_ok, out_q.next_pointer == '0 && !out_q.running)
  `RME_ASSERT_IMP(a_stall_holds_exec, clk_i, rst_ni,
    out_valid_q && !out_o.ready, !exe_go && !(s1_valid_q && in_i.ready))

endmodule
